// ----- hdl/affinity_chunk_scheduler_defines.svh -----
`ifndef AFFINITY_CHUNK_SCHEDULER_DEFINES_SVH
`define AFFINITY_CHUNK_SCHEDULER_DEFINES_SVH

// cons must hold in the same cycle as ante
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acs: check failed");

// cons must hold in the cycle after ante
`define ACS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acs: check failed");

`endif

// ----- hdl/acs_pkg.sv -----
package acs_pkg;

    localparam int FIELD_W   = 21;
    localparam int TID_W     = 3;
    localparam int NT_W      = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_THREADS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK   = 2'd1;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_ASSIGN = 2'd1,
        MODE_LOCAL  = 2'd2,
        MODE_STEAL  = 2'd3
    } t_mode;

    typedef struct packed {
        logic  capture;
        logic  rd_own;
        logic  own_load;
        logic  scan_init;
        logic  rd_scan;
        logic  scan_cmp;
        logic  div_own;
        logic  div_best;
        logic  div_step;
        logic  fin;
        t_mode mode;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic tid_ok;
        logic own_busy;
        logic scan_last;
        logic any;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/acs_ctrl.sv -----
`include "affinity_chunk_scheduler_defines.svh"

module acs_ctrl import acs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_OWN_RD   = 8'b0000_0010,
        S_OWN_CHK  = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CMP = 8'b0001_0000,
        S_SCAN_END = 8'b0010_0000,
        S_DIV      = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [5:0] w_cmd_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_NONE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_cmd      = '0;
        o_cmd.mode = r_mode;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_OWN_RD;
                end
            end
            S_OWN_RD: begin
                if (!i_sts.kind) begin
                    n_mode  = i_sts.tid_ok ? MODE_ASSIGN : MODE_NONE;
                    n_state = S_FIN;
                end else if (!i_sts.tid_ok) begin
                    n_mode  = MODE_NONE;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_own = 1'b1;
                    n_state      = S_OWN_CHK;
                end
            end
            S_OWN_CHK: begin
                o_cmd.own_load = 1'b1;
                if (i_sts.own_busy) begin
                    o_cmd.div_own = 1'b1;
                    n_mode        = MODE_LOCAL;
                    n_state       = S_DIV;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_sts.scan_last ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END: begin
                if (i_sts.any) begin
                    o_cmd.div_best = 1'b1;
                    n_mode         = MODE_STEAL;
                    n_state        = S_DIV;
                end else begin
                    n_mode  = MODE_NONE;
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    assign w_cmd_bits = {o_cmd.capture, o_cmd.rd_own, o_cmd.rd_scan,
                         o_cmd.scan_cmp, o_cmd.div_step, o_cmd.fin};

    `ACS_ASSERT_IMP(a_fin_needs_room, i_clk, i_rst_n, o_cmd.fin, i_sts.out_free)
    `ACS_ASSERT_IMP(a_one_phase, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd_bits))
    `ACS_ASSERT_NXT(a_fin_to_idle, i_clk, i_rst_n, o_cmd.fin, !o_in_stall)

endmodule

// ----- hdl/acs_dp.sv -----
`include "affinity_chunk_scheduler_defines.svh"

module acs_dp import acs_pkg::*; #(
    parameter int MAX_THREADS = 8,
    parameter int INDEX_BITS  = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    input  logic                 i_kind,
    input  logic [TID_W-1:0]     i_thread_id,
    input  logic [FIELD_W-1:0]   i_range_lo,
    input  logic [FIELD_W-1:0]   i_range_hi,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic                 o_stolen,
    output logic [FIELD_W-1:0]   o_chunk_lo,
    output logic [FIELD_W-1:0]   o_chunk_hi
);

    localparam int IW  = INDEX_BITS;
    localparam int AW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW  = (IW > FIELD_W) ? IW : FIELD_W;
    localparam int SW  = CW + 1;
    localparam int DCW = $clog2(IW);

    logic [NT_W-1:0]    r_num_threads;
    logic [FIELD_W-1:0] r_min_chunk;

    logic               r_kind;
    logic [TID_W-1:0]   r_tid;
    logic [IW-1:0]      r_lo, r_hi;

    logic [2*IW-1:0]    r_mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_ent_vld;
    logic [2*IW-1:0]    r_mem_q;
    logic               r_rd_vld;

    logic [IW-1:0]      r_own_ns, r_own_end;
    logic [AW-1:0]      r_scan, r_victim;
    logic               r_any;
    logic [IW-1:0]      r_best, r_vic_ns, r_vic_end;

    logic [IW-1:0]      r_quo;
    logic [NT_W-1:0]    r_part;
    logic [DCW-1:0]     r_dcnt;

    logic               r_out_valid, r_found, r_stolen;
    logic [FIELD_W-1:0] r_chunk_lo, r_chunk_hi;

    logic [IW-1:0]      w_lo, w_hi;
    logic [AW-1:0]      w_tid_addr, w_rd_addr, w_scan_last, w_wr_addr;
    logic [IW-1:0]      w_rd_ns, w_rd_end, w_rd_rem;
    logic [NT_W-1:0]    w_div;
    logic [FIELD_W-1:0] w_least;
    logic [NT_W:0]      w_trial;
    logic               w_ge;
    logic [CW-1:0]      w_q, w_lst, w_chunk;
    logic [SW-1:0]      w_sum;
    logic [IW-1:0]      w_stop, w_first;
    logic               w_we;
    logic [2*IW-1:0]    w_wr_data;

    assign w_lo       = IW'(i_range_lo);
    assign w_hi       = IW'(i_range_hi);
    assign w_tid_addr = AW'(r_tid);
    assign w_rd_addr  = i_cmd.rd_scan ? r_scan : w_tid_addr;

    assign w_rd_ns  = r_rd_vld ? r_mem_q[2*IW-1:IW] : '0;
    assign w_rd_end = r_rd_vld ? r_mem_q[IW-1:0] : '0;
    assign w_rd_rem = (w_rd_end > w_rd_ns) ? (w_rd_end - w_rd_ns) : '0;

    assign w_div   = (r_num_threads == '0) ? NT_W'(1) : r_num_threads;
    assign w_least = (r_min_chunk == '0) ? FIELD_W'(1) : r_min_chunk;
    assign w_scan_last = (int'(w_div) > MAX_THREADS) ? AW'(MAX_THREADS - 1)
                                                     : AW'(w_div - NT_W'(1));

    // restoring divide, one quotient bit per cycle
    assign w_trial = {r_part, r_quo[IW-1]};
    assign w_ge    = (w_trial >= {1'b0, w_div});

    assign w_q     = CW'(r_quo);
    assign w_lst   = CW'(w_least);
    assign w_chunk = (w_q <= w_lst) ? w_lst : w_q;

    assign w_sum   = SW'(r_own_ns) + SW'(w_chunk);
    assign w_stop  = (w_sum > SW'(r_own_end)) ? r_own_end : IW'(w_sum);
    assign w_first = (w_chunk >= CW'(r_best)) ? r_vic_ns : (r_vic_end - IW'(w_chunk));

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = w_tid_addr;
        w_wr_data = {r_lo, r_hi};
        case (i_cmd.mode)
            MODE_ASSIGN: begin
                w_we = i_cmd.fin;
            end
            MODE_LOCAL: begin
                w_we      = i_cmd.fin;
                w_wr_data = {w_stop, r_own_end};
            end
            MODE_STEAL: begin
                w_we      = i_cmd.fin;
                w_wr_addr = r_victim;
                w_wr_data = {r_vic_ns, w_first};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mem_q  <= r_mem[w_rd_addr];
        r_rd_vld <= r_ent_vld[w_rd_addr];
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (w_we) begin
            r_ent_vld[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_threads <= NT_W'(1);
            r_min_chunk   <= FIELD_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_THREADS: r_num_threads <= i_cfg_data[NT_W-1:0];
                CFG_MIN_CHUNK:   r_min_chunk   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_tid  <= i_thread_id;
            r_lo   <= w_lo;
            r_hi   <= (w_hi < w_lo) ? w_lo : w_hi;
        end
        if (i_cmd.own_load) begin
            r_own_ns  <= w_rd_ns;
            r_own_end <= w_rd_end;
        end
        if (i_cmd.scan_init) begin
            r_scan   <= '0;
            r_any    <= 1'b0;
            r_best   <= '0;
            r_victim <= '0;
        end else if (i_cmd.scan_cmp) begin
            r_scan <= r_scan + AW'(1);
            // ties go to the later thread; a zero thread count finds no victim
            if (r_num_threads != '0 && w_rd_rem != '0 &&
                (!r_any || w_rd_rem >= r_best)) begin
                r_any     <= 1'b1;
                r_best    <= w_rd_rem;
                r_victim  <= r_scan;
                r_vic_ns  <= w_rd_ns;
                r_vic_end <= w_rd_end;
            end
        end
        if (i_cmd.div_own || i_cmd.div_best) begin
            r_quo  <= i_cmd.div_own ? w_rd_rem : r_best;
            r_part <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_part <= w_ge ? NT_W'(w_trial - {1'b0, w_div}) : w_trial[NT_W-1:0];
            r_quo  <= {r_quo[IW-2:0], w_ge};
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_found    <= 1'b0;
            r_stolen   <= 1'b0;
            r_chunk_lo <= '0;
            r_chunk_hi <= '0;
            if (i_cmd.mode == MODE_LOCAL) begin
                r_found    <= 1'b1;
                r_chunk_lo <= FIELD_W'(r_own_ns);
                r_chunk_hi <= FIELD_W'(w_stop);
            end else if (i_cmd.mode == MODE_STEAL) begin
                r_found    <= 1'b1;
                r_stolen   <= 1'b1;
                r_chunk_lo <= FIELD_W'(w_first);
                r_chunk_hi <= FIELD_W'(r_vic_end);
            end
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.tid_ok    = (int'(r_tid) < MAX_THREADS);
    assign o_sts.own_busy  = (w_rd_rem != '0);
    assign o_sts.scan_last = (r_scan == w_scan_last);
    assign o_sts.any       = r_any;
    assign o_sts.div_last  = (r_dcnt == DCW'(IW - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_stolen    = r_stolen;
    assign o_chunk_lo  = r_chunk_lo;
    assign o_chunk_hi  = r_chunk_hi;

    `ACS_ASSERT_IMP(a_local_advances, i_clk, i_rst_n,
        i_cmd.fin && i_cmd.mode == MODE_LOCAL, w_stop > r_own_ns)
    `ACS_ASSERT_IMP(a_steal_in_range, i_clk, i_rst_n,
        i_cmd.fin && i_cmd.mode == MODE_STEAL, w_first < r_vic_end && w_first >= r_vic_ns)
    `ACS_ASSERT_IMP(a_victim_has_work, i_clk, i_rst_n, i_cmd.div_best, r_any && r_best != '0)

endmodule

// ----- hdl/affinity_chunk_scheduler.sv -----
// Loop chunk scheduler with per-thread ranges and work stealing. An assign
// request loads a thread's [lo, hi) range; a grant request takes
// max(min_chunk, remaining / num_threads) iterations from the front of the
// requester's range, or, when that range is empty, from the back of the
// busiest range among the first num_threads threads (ties to the higher
// index). Every request gives exactly one result. Requests are handled one
// at a time; a new one is taken as soon as the previous has been placed in
// the output register, even while that result is still stalled.
// The chunk size comes from a one-bit-per-cycle divider, and the scan reads
// the thread entries one at a time, a read state and then a compare state
// for each, through the single read port of the range table.
module affinity_chunk_scheduler import acs_pkg::*; #(
    parameter int MAX_THREADS = 8,
    parameter int INDEX_BITS  = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [TID_W-1:0]     i_thread_id,
    input  logic [FIELD_W-1:0]   i_range_lo,
    input  logic [FIELD_W-1:0]   i_range_hi,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic                 o_stolen,
    output logic [FIELD_W-1:0]   o_chunk_lo,
    output logic [FIELD_W-1:0]   o_chunk_hi
);

    t_cmd w_cmd;
    t_sts w_sts;

    acs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    acs_dp #(
        .MAX_THREADS (MAX_THREADS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (i_kind),
        .i_thread_id (i_thread_id),
        .i_range_lo  (i_range_lo),
        .i_range_hi  (i_range_hi),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_stolen    (o_stolen),
        .o_chunk_lo  (o_chunk_lo),
        .o_chunk_hi  (o_chunk_hi)
    );

endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import acs_pkg::*;

    localparam int THREAD_SLOTS   = 8;
    localparam int RANDOM_ITEMS   = 900;
    localparam int PHASES         = 10;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 60;

    localparam bit KIND_ASSIGN  = 1'b0;
    localparam bit KIND_REQUEST = 1'b1;

    // unused register slots, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [NT_W-1:0] NT_PLAN [PHASES] =
        '{4'd1, 4'd8, 4'd4, 4'd15, 4'd0, 4'd8, 4'd2, 4'd6, 4'd5, 4'd3};
    localparam logic [FIELD_W-1:0] MIN_PLAN [PHASES] =
        '{21'd1, 21'd1, 21'd3, 21'd2, 21'd5, 21'h100000, 21'h1FFFFF, 21'd0, 21'd1, 21'd7};

    typedef struct packed {
        logic               found;
        logic               stolen;
        logic [FIELD_W-1:0] chunk_lo;
        logic [FIELD_W-1:0] chunk_hi;
    } t_grant;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FIELD_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_kind;
    logic [TID_W-1:0]     i_thread_id;
    logic [FIELD_W-1:0]   i_range_lo;
    logic [FIELD_W-1:0]   i_range_hi;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_found;
    logic                 o_stolen;
    logic [FIELD_W-1:0]   o_chunk_lo;
    logic [FIELD_W-1:0]   o_chunk_hi;

    class chunk_ledger;
        logic [NT_W-1:0]    num_threads;
        logic [FIELD_W-1:0] min_chunk;
        logic [FIELD_W-1:0] next_start [THREAD_SLOTS];
        logic [FIELD_W-1:0] range_end  [THREAD_SLOTS];
        t_grant             grants_due [$];
        int                 errors;

        function new();
            num_threads = NT_W'(1);
            min_chunk   = FIELD_W'(1);
            errors      = 0;
            foreach (next_start[t]) begin
                next_start[t] = '0;
                range_end[t]  = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [FIELD_W-1:0] data);
            case (index)
                CFG_NUM_THREADS: num_threads = data[NT_W-1:0];
                CFG_MIN_CHUNK:   min_chunk = data;
                default: ;
            endcase
        endfunction

        function int unsigned work_left(int t);
            int unsigned e;
            int unsigned s;
            e = range_end[t];
            s = next_start[t];
            return (e > s) ? e - s : 0;
        endfunction

        function int unsigned chunk_for(int unsigned rem);
            int unsigned divisor;
            int unsigned least;
            int unsigned share;
            divisor = (num_threads == 0) ? 1 : num_threads;
            least   = (min_chunk == 0) ? 1 : min_chunk;
            share   = rem / divisor;
            return (share <= least) ? least : share;
        endfunction

        function void note_request(bit kind, logic [TID_W-1:0] tid,
                                   logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
            t_grant      g;
            int unsigned rem;
            int unsigned stop;
            int unsigned top;
            int unsigned size;
            int unsigned best;
            int          scan;
            int          victim;
            bit          found_one;
            g = '0;
            if (kind == KIND_ASSIGN) begin
                next_start[tid] = lo;
                range_end[tid]  = (hi < lo) ? lo : hi;
            end else if (work_left(tid) > 0) begin
                rem  = work_left(tid);
                stop = next_start[tid] + chunk_for(rem);
                if (stop > range_end[tid])
                    stop = range_end[tid];
                g.found    = 1'b1;
                g.chunk_lo = next_start[tid];
                g.chunk_hi = stop[FIELD_W-1:0];
                next_start[tid] = stop[FIELD_W-1:0];
            end else begin
                // steal from the busiest thread, ties to the higher index
                scan      = (num_threads > THREAD_SLOTS) ? THREAD_SLOTS : num_threads;
                found_one = 1'b0;
                best      = 0;
                victim    = 0;
                for (int i = 0; i < scan; i++) begin
                    rem = work_left(i);
                    if (rem > 0 && (!found_one || rem >= best)) begin
                        found_one = 1'b1;
                        best      = rem;
                        victim    = i;
                    end
                end
                if (found_one) begin
                    top  = range_end[victim];
                    size = chunk_for(best);
                    g.found    = 1'b1;
                    g.stolen   = 1'b1;
                    g.chunk_lo = FIELD_W'((size >= best) ? next_start[victim] : top - size);
                    g.chunk_hi = top[FIELD_W-1:0];
                    range_end[victim] = g.chunk_lo;
                end
            end
            grants_due.push_back(g);
        endfunction

        function void check_grant(logic found, logic stolen,
                                  logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
            t_grant want;
            if (grants_due.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result found %0b stolen %0b chunk [%0d, %0d)",
                         $time, found, stolen, lo, hi);
                return;
            end
            want = grants_due.pop_front();
            if (found !== want.found) begin
                errors++;
                $display("%0t ns: found expected %0b, got %0b", $time, want.found, found);
            end
            if (stolen !== want.stolen) begin
                errors++;
                $display("%0t ns: stolen expected %0b, got %0b", $time, want.stolen, stolen);
            end
            if (lo !== want.chunk_lo) begin
                errors++;
                $display("%0t ns: chunk_lo expected %0d, got %0d", $time, want.chunk_lo, lo);
            end
            if (hi !== want.chunk_hi) begin
                errors++;
                $display("%0t ns: chunk_hi expected %0d, got %0d", $time, want.chunk_hi, hi);
            end
        endfunction
    endclass

    chunk_ledger ledger = new();
    int          sent = 0;
    int          tx_gap_max = 7;
    int          rx_gap_max = 7;
    bit          rx_hold_req = 1'b0;
    int          quiet_cycles = 0;

    affinity_chunk_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_thread_id (i_thread_id),
        .i_range_lo  (i_range_lo),
        .i_range_hi  (i_range_hi),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_stolen    (o_stolen),
        .o_chunk_lo  (o_chunk_lo),
        .o_chunk_hi  (o_chunk_hi)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic push_request(bit kind, logic [TID_W-1:0] tid,
                                logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_thread_id <= tid;
        i_range_lo  <= lo;
        i_range_hi  <= hi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ledger.note_request(kind, tid, lo, hi);
        sent++;
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (ledger.grants_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg_port(logic [CFG_IDX_W-1:0] index, logic [FIELD_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        ledger.write_reg(index, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [NT_W-1:0] nt, logic [FIELD_W-1:0] least);
        logic [FIELD_W-1:0] nt_word;
        nt_word = FIELD_W'($urandom());
        nt_word[NT_W-1:0] = nt;
        write_reg_port(CFG_NUM_THREADS, nt_word);
        write_reg_port(CFG_MIN_CHUNK, least);
        write_reg_port($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                       FIELD_W'($urandom()));
    endtask

    // assign a few ranges, then mostly grant requests against them
    task automatic run_episode();
        int                 n_assign;
        int                 n_req;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        n_assign = $urandom_range(1, 6);
        repeat (n_assign) begin
            lo = FIELD_W'($urandom());
            case ($urandom_range(0, 9))
                0: hi = FIELD_W'($urandom());
                1: hi = FIELD_W'(lo - $urandom_range(1, 50));
                2: begin
                    lo = FIELD_W'($urandom_range(0, 3));
                    hi = FIELD_W'(lo + $urandom_range(0, 5));
                end
                default: hi = FIELD_W'(lo + $urandom_range(0, 400));
            endcase
            push_request(KIND_ASSIGN, TID_W'($urandom()), lo, hi);
        end
        n_req = $urandom_range(4, 40);
        repeat (n_req) begin
            if ($urandom_range(0, 11) == 0)
                push_request(KIND_ASSIGN, TID_W'($urandom()), FIELD_W'($urandom()),
                             FIELD_W'($urandom()));
            else
                push_request(KIND_REQUEST, TID_W'($urandom()), FIELD_W'($urandom()),
                             FIELD_W'($urandom()));
        end
    endtask

    initial begin : out_side
        int hold;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req) begin
                hold = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                hold = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.check_grant(o_found, o_stolen, o_chunk_lo, o_chunk_hi);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: nothing moved for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase_end;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_NUM_THREADS;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_kind      <= KIND_ASSIGN;
        i_thread_id <= '0;
        i_range_lo  <= '0;
        i_range_hi  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one thread, minimum chunk 1
        push_request(KIND_REQUEST, 3'd0, 21'd0, 21'd0);
        push_request(KIND_ASSIGN,  3'd0, 21'd10, 21'd20);
        push_request(KIND_REQUEST, 3'd0, 21'd0, 21'd0);
        push_request(KIND_REQUEST, 3'd0, 21'd0, 21'd0);
        push_request(KIND_ASSIGN,  3'd5, 21'h1FFFFF, 21'd0);
        push_request(KIND_ASSIGN,  3'd7, 21'd0, 21'h1FFFFF);
        push_request(KIND_REQUEST, 3'd5, 21'h1FFFFF, 21'h1FFFFF);
        push_request(KIND_REQUEST, 3'd7, 21'd0, 21'd0);
        drain_requests();
        set_config(4'd4, 21'd2);
        push_request(KIND_ASSIGN,  3'd1, 21'd0, 21'h1FFFFF);
        push_request(KIND_ASSIGN,  3'd2, 21'd100, 21'd108);
        push_request(KIND_REQUEST, 3'd1, 21'd0, 21'd0);
        push_request(KIND_REQUEST, 3'd3, 21'd0, 21'd0);
        push_request(KIND_ASSIGN,  3'd1, 21'd200, 21'd208);
        push_request(KIND_ASSIGN,  3'd0, 21'd300, 21'd308);
        push_request(KIND_REQUEST, 3'd3, 21'd0, 21'd0);
        push_request(KIND_ASSIGN,  3'd2, 21'd50, 21'd51);
        push_request(KIND_ASSIGN,  3'd0, 21'd0, 21'd0);
        push_request(KIND_ASSIGN,  3'd1, 21'd0, 21'd0);
        push_request(KIND_REQUEST, 3'd3, 21'd0, 21'd0);
        drain_requests();
        set_config(4'd0, 21'd0);
        push_request(KIND_ASSIGN,  3'd4, 21'd1000, 21'd1010);
        push_request(KIND_REQUEST, 3'd4, 21'd0, 21'd0);
        push_request(KIND_REQUEST, 3'd6, 21'd0, 21'd0);
        drain_requests();
        set_config(4'd15, 21'd1);
        push_request(KIND_ASSIGN,  3'd7, 21'd0, 21'd300);
        push_request(KIND_REQUEST, 3'd0, 21'd0, 21'd0);
        push_request(KIND_REQUEST, 3'd7, 21'd0, 21'd0);

        for (int p = 0; p < PHASES; p++) begin
            drain_requests();
            set_config(NT_PLAN[p], MIN_PLAN[p]);
            phase_end = sent + RANDOM_ITEMS / PHASES;
            if (p == 1) begin
                // long output hold while requests keep coming
                tx_gap_max  = 0;
                rx_hold_req = 1'b1;
                run_episode();
            end
            while (sent < phase_end) begin
                tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
                rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
                run_episode();
                if ($urandom_range(0, 7) == 0)
                    drain_requests();
            end
        end

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.grants_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
